// File: rtl/psh_pkg.sv
// Shared types, widths and constants for the polynomial string hash.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package psh_pkg;

  // field widths
  localparam int CHAR_W = 8;
  localparam int HASH_W = 32;
  localparam int WIDE_W = 64;
  localparam int TERM_W = CHAR_W + 1;

  // hash constants
  localparam logic [TERM_W-1:0] CHAR_OFFSET = TERM_W'(96);
  localparam int BASE_SHIFT = 5;  // 31 = 2^5 - 1
  localparam logic [HASH_W-1:0] MOD_RESET = HASH_W'(2);
  localparam logic [HASH_W-1:0] PWR_RESET = HASH_W'(1);

  // remainder unit step counts
  localparam int STEP_W = $clog2(WIDE_W + 1);
  localparam int PWR_W = HASH_W + BASE_SHIFT;
  localparam logic [STEP_W-1:0] IDX_STEPS = STEP_W'(WIDE_W);
  localparam logic [STEP_W-1:0] PWR_STEPS = STEP_W'(PWR_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_IDX,
    ST_PWR,
    ST_PUSH
  } state_t;

  // request to the remainder unit; dividend is MSB-aligned
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [WIDE_W-1:0] dividend;
  } rem_ctl_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] remainder;
  } rem_sts_t;

endpackage

`default_nettype wire

// File: rtl/psh_if.sv
// Valid/ready channel interfaces for the string hash input and result items.
// Depends on psh_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface psh_in_if;
  logic                        valid;
  logic                        ready;
  logic [psh_pkg::CHAR_W-1:0]  char_code;
  logic                        is_last;

  modport source (output valid, char_code, is_last, input ready);
  modport sink   (input valid, char_code, is_last, output ready);
endinterface

interface psh_out_if;
  logic                        valid;
  logic                        ready;
  logic [psh_pkg::HASH_W-1:0]  hash_index;

  modport source (output valid, hash_index, input ready);
  modport sink   (input valid, hash_index, output ready);
endinterface

`default_nettype wire

// File: rtl/psh_rem_unit.sv
// Bit-serial restoring remainder unit: shifts the dividend in one bit per cycle.
// Depends on psh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psh_rem_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [psh_pkg::HASH_W-1:0] modulus,
  input  wire psh_pkg::rem_ctl_t          ctl,
  output psh_pkg::rem_sts_t               sts
);
  import psh_pkg::*;

  logic [WIDE_W-1:0] dvd_r, dvd_nxt;
  logic [HASH_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [HASH_W:0]   trial;
  logic [HASH_W:0]   diff;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dvd_r[WIDE_W-1]};
    diff  = trial - {1'b0, modulus};
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      dvd_nxt = ctl.dividend;
      rem_nxt = '0;
      cnt_nxt = ctl.steps;
    end else if (cnt_r != '0) begin
      dvd_nxt  = {dvd_r[WIDE_W-2:0], 1'b0};
      rem_nxt  = (trial >= {1'b0, modulus}) ? diff[HASH_W-1:0] : trial[HASH_W-1:0];
      cnt_nxt  = cnt_r - STEP_W'(1);
      done_nxt = (cnt_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.done      = done_r;
  assign sts.remainder = rem_r;

endmodule

`default_nettype wire

// File: rtl/polynomial_string_hash.sv
// Top level of the polynomial rolling string hash: sequencer, state, output register.
// Depends on psh_pkg, psh_if and psh_rem_unit.
//
//   channel  | dir | handshake      | payload
//   in_ch    | in  | valid/ready    | char_code[7:0], is_last
//   out_ch   | out | valid/ready    | hash_index[31:0]
//   cfg      | in  | cfg_we         | cfg_wdata[31:0] (modulus)
//
// A byte that is not last runs, from acceptance to the next ready: the load,
// 64 remainder steps on the index sum, a turnaround, then 37 steps on power*31.
// A last byte runs the load, 64 index steps and any wait for a free output register.
// All steps run on the single bit-serial remainder unit, one bit a cycle.
// Synchronous active-low reset: index 0, power 1, modulus 2, output empty.
// A held result in the output register does not stall the sequencer until the
// next last byte needs that register.
`timescale 1ns / 1ps
`default_nettype none

module polynomial_string_hash (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  psh_in_if.sink                          in_ch,
  psh_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [psh_pkg::HASH_W-1:0] cfg_wdata
);
  import psh_pkg::*;

  state_t            state_r, state_nxt;
  logic [HASH_W-1:0] mod_r;
  logic [HASH_W-1:0] mod_eff;
  logic [HASH_W-1:0] index_r;
  logic [HASH_W-1:0] power_r;
  logic              last_r;
  logic              out_valid_r;
  logic [HASH_W-1:0] out_hash_r;

  logic              in_fire;
  logic              out_free;
  logic              push;
  rem_ctl_t          rem_ctl;
  rem_sts_t          rem_sts;

  logic signed [TERM_W-1:0]   term;
  logic signed [HASH_W:0]     pwr_s;
  logic signed [TERM_W+HASH_W:0] prod;
  logic [WIDE_W-1:0]          sum64;
  logic [PWR_W-1:0]           pwr31;

  // a modulus of zero behaves as one
  assign mod_eff = (mod_r == '0) ? HASH_W'(1) : mod_r;

  // term = signed byte - 96, times power, plus index, wrapped to 64 bits
  always_comb begin
    term  = $signed({in_ch.char_code[CHAR_W-1], in_ch.char_code}) - $signed(CHAR_OFFSET);
    pwr_s = $signed({1'b0, power_r});
    prod  = term * pwr_s;
    sum64 = WIDE_W'({{(WIDE_W-TERM_W-HASH_W-1){prod[TERM_W+HASH_W]}}, prod})
            + {{(WIDE_W-HASH_W){1'b0}}, index_r};
    pwr31 = {power_r, BASE_SHIFT'(0)} - {BASE_SHIFT'(0), power_r};
  end

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_IDX;
      ST_IDX: begin
        if (rem_sts.done) state_nxt = last_r ? ST_PUSH : ST_PWR;
      end
      ST_PWR:  if (rem_sts.done) state_nxt = ST_IDLE;
      ST_PUSH: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready      = 1'b0;
    push             = 1'b0;
    rem_ctl.start    = 1'b0;
    rem_ctl.steps    = IDX_STEPS;
    rem_ctl.dividend = sum64;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready   = 1'b1;
        rem_ctl.start = in_ch.valid;
      end
      ST_IDX: begin
        if (rem_sts.done && !last_r) begin
          rem_ctl.start    = 1'b1;
          rem_ctl.steps    = PWR_STEPS;
          rem_ctl.dividend = {pwr31, (WIDE_W-PWR_W)'(0)};
        end
      end
      ST_PWR: ;
      ST_PUSH: push = out_free;
      default: ;
    endcase
  end

  psh_rem_unit u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (mod_eff),
    .ctl     (rem_ctl),
    .sts     (rem_sts)
  );

  // state, running values and modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mod_r   <= MOD_RESET;
      index_r <= '0;
      power_r <= PWR_RESET;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) mod_r <= cfg_wdata;
      if (in_fire) last_r <= in_ch.is_last;
      if (push) begin
        index_r <= '0;
        power_r <= PWR_RESET;
      end else if (state_r == ST_IDX && rem_sts.done) begin
        index_r <= rem_sts.remainder;
      end else if (state_r == ST_PWR && rem_sts.done) begin
        power_r <= rem_sts.remainder;
      end
    end
  end

  // output register: load on push, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (push) out_hash_r <= index_r;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_index = out_hash_r;

endmodule

`default_nettype wire
